// ===== sv/scsiq_pkg.sv =====
// ----------------------------------------------------------------------------
// scsiq_pkg
// shared widths, codes and item type for the sparse column store
// ----------------------------------------------------------------------------
package scsiq_pkg;

	localparam int MAX_COLUMNS = 256;
	localparam int MAX_ENTRIES = 4096;
	localparam int MAX_ROWS    = 1024;

	localparam int OP_W   = 2;
	localparam int ROW_W  = 10;
	localparam int COL_W  = 8;
	localparam int POS_W  = 12;
	localparam int ST_W   = 3;
	localparam int CNT_W  = 13;
	localparam int BND_W  = 11;
	localparam int CFG_W  = 9;
	localparam int CS_AW  = $clog2(MAX_COLUMNS + 1);
	localparam int RS_AW  = $clog2(MAX_ENTRIES);

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_COUNT  = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

	localparam logic [ST_W-1:0] ST_OK   = 3'd0;
	localparam logic [ST_W-1:0] ST_DUP  = 3'd1;
	localparam logic [ST_W-1:0] ST_COL  = 3'd2;
	localparam logic [ST_W-1:0] ST_FULL = 3'd3;
	localparam logic [ST_W-1:0] ST_POS  = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [POS_W-1:0] pos;
		logic             nop;
		logic             col_bad;
	} item_t;

endpackage

// ===== sv/scsiq_front.sv =====
// ----------------------------------------------------------------------------
// scsiq_front
// accepts input beats, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
module scsiq_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [scsiq_pkg::OP_W-1:0]        opcode,
	input  logic [scsiq_pkg::ROW_W-1:0]       row_index,
	input  logic [scsiq_pkg::COL_W-1:0]       column_index,
	input  logic [scsiq_pkg::POS_W-1:0]       position,
	input  logic [scsiq_pkg::CFG_W-1:0]       cols_cfg,
	input  logic                              clearing,
	output logic                              q_valid,
	output scsiq_pkg::item_t                  q_item,
	input  logic                              q_pop
);

	scsiq_pkg::item_t       ent_q [2];
	logic                   wp_q, rp_q;
	logic [1:0]             cnt_q;
	logic [scsiq_pkg::CFG_W-1:0] active;
	scsiq_pkg::item_t       cls;
	logic                   push;

	always_comb begin
		active = (cols_cfg > scsiq_pkg::CFG_W'(scsiq_pkg::MAX_COLUMNS)) ?
			scsiq_pkg::CFG_W'(scsiq_pkg::MAX_COLUMNS) : cols_cfg;
		cls.op      = opcode;
		cls.row     = row_index;
		cls.col     = column_index;
		cls.pos     = position;
		cls.nop     = (opcode != scsiq_pkg::OP_INSERT) && (opcode != scsiq_pkg::OP_COUNT) &&
			(opcode != scsiq_pkg::OP_READ);
		cls.col_bad = ({1'b0, column_index} >= active) && !cls.nop;
	end

	assign in_stall = (cnt_q == 2'd2) || clearing;
	assign push     = in_valid && !in_stall;
	assign q_valid  = cnt_q != 2'd0;
	assign q_item   = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (q_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

// ===== sv/scsiq_back.sv =====
// ----------------------------------------------------------------------------
// scsiq_back
// sequencer that runs queries and inserts on the column pointer and row stores
// ----------------------------------------------------------------------------
module scsiq_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	input  scsiq_pkg::item_t                  q_item,
	output logic                              q_pop,
	output logic                              clearing,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [scsiq_pkg::ST_W-1:0]        status,
	output logic [scsiq_pkg::ROW_W-1:0]       row_value,
	output logic [scsiq_pkg::CNT_W-1:0]       entries_in_column,
	output logic [scsiq_pkg::CNT_W-1:0]       entries_total,
	output logic [scsiq_pkg::BND_W-1:0]       row_extent
);

	localparam int CNT_W = scsiq_pkg::CNT_W;
	localparam int CS_AW = scsiq_pkg::CS_AW;
	localparam int RS_AW = scsiq_pkg::RS_AW;
	localparam int BK_W  = CS_AW + 1;
	localparam int BND_W = scsiq_pkg::BND_W;

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_RDA   = 4'd2;
	localparam logic [3:0] S_RDB   = 4'd3;
	localparam logic [3:0] S_RDC   = 4'd4;
	localparam logic [3:0] S_RDROW = 4'd5;
	localparam logic [3:0] S_SCAN  = 4'd6;
	localparam logic [3:0] S_SHIFT = 4'd7;
	localparam logic [3:0] S_PUT   = 4'd8;
	localparam logic [3:0] S_BUMP  = 4'd9;
	localparam logic [3:0] S_DONE  = 4'd10;

	logic [CNT_W-1:0] cs_mem [scsiq_pkg::MAX_COLUMNS+1];
	logic [scsiq_pkg::ROW_W-1:0] rs_mem [scsiq_pkg::MAX_ENTRIES];

	logic [3:0]       state_q;
	scsiq_pkg::item_t it_q;
	logic [CS_AW-1:0] clr_q;
	logic [CNT_W-1:0] first_q, last_q, at_q, k_q, count_q;
	logic [BND_W-1:0] bound_q;
	logic [BK_W-1:0]  bk_q;
	logic             pend_q, cpend_q;
	logic [RS_AW-1:0] pend_addr_q;
	logic [CS_AW-1:0] cpend_addr_q;
	logic [CNT_W-1:0] cs_rd_q;
	logic [scsiq_pkg::ROW_W-1:0] rs_rd_q;

	logic [scsiq_pkg::ST_W-1:0]  r_st_q;
	logic [scsiq_pkg::ROW_W-1:0] r_rv_q;
	logic [CNT_W-1:0]            r_cnt_q;
	logic                        ov_q;
	logic [scsiq_pkg::ST_W-1:0]  o_st_q;
	logic [scsiq_pkg::ROW_W-1:0] o_rv_q;
	logic [CNT_W-1:0]            o_cnt_q, o_tot_q;
	logic [BND_W-1:0]            o_bnd_q;

	logic [CS_AW-1:0] cs_raddr, cs_waddr;
	logic [CNT_W-1:0] cs_wdata;
	logic             cs_we;
	logic [RS_AW-1:0] rs_raddr, rs_waddr;
	logic [scsiq_pkg::ROW_W-1:0] rs_wdata;
	logic             rs_we;
	logic [CNT_W-1:0] cnt_now, rd_sum, row1;
	logic             scan_go;
	logic             out_free;

	assign clearing = state_q == S_CLR;
	assign out_free = !ov_q || !out_stall;
	assign q_pop    = (state_q == S_IDLE) && q_valid;
	assign cnt_now  = cs_rd_q - first_q;
	assign rd_sum   = first_q + CNT_W'(it_q.pos);
	assign row1     = CNT_W'(it_q.row) + CNT_W'(1);
	assign scan_go  = (at_q < last_q) && (rs_rd_q < it_q.row);

	always_comb begin
		cs_raddr = CS_AW'(it_q.col);
		cs_we    = 1'b0;
		cs_waddr = cpend_addr_q;
		cs_wdata = cs_rd_q + CNT_W'(1);
		rs_raddr = first_q[RS_AW-1:0];
		rs_we    = 1'b0;
		rs_waddr = pend_addr_q;
		rs_wdata = rs_rd_q;
		case (state_q)
			S_CLR: begin
				cs_we    = 1'b1;
				cs_waddr = clr_q;
				cs_wdata = '0;
			end
			S_RDB: cs_raddr = CS_AW'(it_q.col) + CS_AW'(1);
			S_RDC: begin
				if (it_q.op == scsiq_pkg::OP_READ) begin
					rs_raddr = rd_sum[RS_AW-1:0];
				end
			end
			S_SCAN: rs_raddr = RS_AW'(at_q + CNT_W'(1));
			S_SHIFT: begin
				rs_raddr = RS_AW'(k_q - CNT_W'(1));
				rs_we    = pend_q;
			end
			S_PUT: begin
				rs_we    = 1'b1;
				rs_waddr = at_q[RS_AW-1:0];
				rs_wdata = it_q.row;
			end
			S_BUMP: begin
				cs_raddr = bk_q[CS_AW-1:0];
				cs_we    = cpend_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cs_we) begin
			cs_mem[cs_waddr] <= cs_wdata;
		end
		cs_rd_q <= cs_mem[cs_raddr];
		if (rs_we) begin
			rs_mem[rs_waddr] <= rs_wdata;
		end
		rs_rd_q <= rs_mem[rs_raddr];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			it_q <= q_item;
		end
		case (state_q)
			S_IDLE: begin
				r_st_q  <= q_item.col_bad ? scsiq_pkg::ST_COL : scsiq_pkg::ST_OK;
				r_rv_q  <= '0;
				r_cnt_q <= '0;
			end
			S_RDB: first_q <= cs_rd_q;
			S_RDC: begin
				last_q  <= cs_rd_q;
				at_q    <= first_q;
				r_cnt_q <= cnt_now;
				if (it_q.op == scsiq_pkg::OP_READ && CNT_W'(it_q.pos) >= cnt_now) begin
					r_st_q <= scsiq_pkg::ST_POS;
				end
			end
			S_RDROW: r_rv_q <= rs_rd_q;
			S_SCAN: begin
				if (scan_go) begin
					at_q <= at_q + CNT_W'(1);
				end else if ((at_q < last_q) && (rs_rd_q == it_q.row)) begin
					r_st_q <= scsiq_pkg::ST_DUP;
				end else if ({1'b0, it_q.row} >= (scsiq_pkg::ROW_W+1)'(scsiq_pkg::MAX_ROWS)) begin
					r_st_q <= scsiq_pkg::ST_POS;
				end else if (count_q >= CNT_W'(scsiq_pkg::MAX_ENTRIES)) begin
					r_st_q <= scsiq_pkg::ST_FULL;
				end
				k_q <= count_q;
			end
			S_SHIFT: begin
				pend_addr_q <= k_q[RS_AW-1:0];
				if (k_q > at_q) begin
					k_q <= k_q - CNT_W'(1);
				end
			end
			S_PUT: bk_q <= BK_W'(it_q.col) + BK_W'(1);
			S_BUMP: begin
				cpend_addr_q <= bk_q[CS_AW-1:0];
				bk_q         <= bk_q + BK_W'(1);
				r_cnt_q      <= last_q + CNT_W'(1) - first_q;
			end
			default: ;
		endcase
		if (state_q == S_DONE && out_free) begin
			o_st_q  <= r_st_q;
			o_rv_q  <= r_rv_q;
			o_cnt_q <= r_cnt_q;
			o_tot_q <= count_q;
			o_bnd_q <= bound_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			count_q <= '0;
			bound_q <= '0;
			pend_q  <= 1'b0;
			cpend_q <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + CS_AW'(1);
					if (clr_q == CS_AW'(scsiq_pkg::MAX_COLUMNS)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_valid) begin
						state_q <= (q_item.nop || q_item.col_bad) ? S_DONE : S_RDA;
					end
				end
				S_RDA: state_q <= S_RDB;
				S_RDB: state_q <= S_RDC;
				S_RDC: begin
					case (it_q.op)
						scsiq_pkg::OP_INSERT: state_q <= S_SCAN;
						scsiq_pkg::OP_READ:
							state_q <= (CNT_W'(it_q.pos) < cnt_now) ? S_RDROW : S_DONE;
						default: state_q <= S_DONE;
					endcase
				end
				S_RDROW: state_q <= S_DONE;
				S_SCAN: begin
					if (!scan_go) begin
						if (((at_q < last_q) && (rs_rd_q == it_q.row)) ||
							({1'b0, it_q.row} >= (scsiq_pkg::ROW_W+1)'(scsiq_pkg::MAX_ROWS)) ||
							(count_q >= CNT_W'(scsiq_pkg::MAX_ENTRIES))) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_SHIFT;
						end
					end
				end
				S_SHIFT: begin
					if (k_q > at_q) begin
						pend_q <= 1'b1;
					end else begin
						pend_q  <= 1'b0;
						state_q <= S_PUT;
					end
				end
				S_PUT: state_q <= S_BUMP;
				S_BUMP: begin
					if (bk_q <= BK_W'(scsiq_pkg::MAX_COLUMNS)) begin
						cpend_q <= 1'b1;
					end else begin
						cpend_q <= 1'b0;
						count_q <= count_q + CNT_W'(1);
						if (BND_W'(row1) > bound_q) begin
							bound_q <= BND_W'(row1);
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid         = ov_q;
	assign status            = o_st_q;
	assign row_value         = o_rv_q;
	assign entries_in_column = o_cnt_q;
	assign entries_total     = o_tot_q;
	assign row_extent        = o_bnd_q;

endmodule

// ===== sv/sparse_column_store_insert_query.sv =====
// ----------------------------------------------------------------------------
// sparse_column_store_insert_query
// compressed sparse column store with sorted insert and column queries
// insert: scans the column, shifts later entries up and bumps the column pointers above
// one item at a time in the back sequencer; a 2-beat queue sits in front
// reset: a clearing pass over all 257 column pointers, input stalled
// ----------------------------------------------------------------------------
module sparse_column_store_insert_query (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [scsiq_pkg::CFG_W-1:0]       cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [scsiq_pkg::OP_W-1:0]        opcode,
	input  logic [scsiq_pkg::ROW_W-1:0]       row_index,
	input  logic [scsiq_pkg::COL_W-1:0]       column_index,
	input  logic [scsiq_pkg::POS_W-1:0]       position,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [scsiq_pkg::ST_W-1:0]        status,
	output logic [scsiq_pkg::ROW_W-1:0]       row_value,
	output logic [scsiq_pkg::CNT_W-1:0]       entries_in_column,
	output logic [scsiq_pkg::CNT_W-1:0]       entries_total,
	output logic [scsiq_pkg::BND_W-1:0]       row_extent
);

	logic [scsiq_pkg::CFG_W-1:0] cols_q;
	logic                        clearing, q_valid, q_pop;
	scsiq_pkg::item_t            q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= scsiq_pkg::CFG_W'(scsiq_pkg::MAX_COLUMNS);
		end else if (cfg_wen) begin
			cols_q <= cfg_data;
		end
	end

	scsiq_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.row_index    (row_index),
		.column_index (column_index),
		.position     (position),
		.cols_cfg     (cols_q),
		.clearing     (clearing),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop)
	);

	scsiq_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_valid           (q_valid),
		.q_item            (q_item),
		.q_pop             (q_pop),
		.clearing          (clearing),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.status            (status),
		.row_value         (row_value),
		.entries_in_column (entries_in_column),
		.entries_total     (entries_total),
		.row_extent        (row_extent)
	);

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// checks the sparse column store: sorted inserts, duplicates, bound errors,
// column counts and positional reads against a behavioral copy of the store,
// with random idling on both sides and several column-count settings
// ----------------------------------------------------------------------------
module tb_top;

	localparam int MAX_COLUMNS = scsiq_pkg::MAX_COLUMNS;
	localparam int MAX_ENTRIES = scsiq_pkg::MAX_ENTRIES;
	localparam int OP_W  = scsiq_pkg::OP_W;
	localparam int ROW_W = scsiq_pkg::ROW_W;
	localparam int COL_W = scsiq_pkg::COL_W;
	localparam int POS_W = scsiq_pkg::POS_W;
	localparam int ST_W  = scsiq_pkg::ST_W;
	localparam int CNT_W = scsiq_pkg::CNT_W;
	localparam int BND_W = scsiq_pkg::BND_W;
	localparam int CFG_W = scsiq_pkg::CFG_W;

	localparam logic [OP_W-1:0] OP_INSERT = scsiq_pkg::OP_INSERT;
	localparam logic [OP_W-1:0] OP_COUNT  = scsiq_pkg::OP_COUNT;
	localparam logic [OP_W-1:0] OP_READ   = scsiq_pkg::OP_READ;
	localparam logic [OP_W-1:0] OP_NONE   = scsiq_pkg::OP_NONE;

	localparam logic [ST_W-1:0] ST_OK   = scsiq_pkg::ST_OK;
	localparam logic [ST_W-1:0] ST_DUP  = scsiq_pkg::ST_DUP;
	localparam logic [ST_W-1:0] ST_COL  = scsiq_pkg::ST_COL;
	localparam logic [ST_W-1:0] ST_FULL = scsiq_pkg::ST_FULL;
	localparam logic [ST_W-1:0] ST_POS  = scsiq_pkg::ST_POS;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [ROW_W-1:0] row_value;
		logic [CNT_W-1:0] in_col;
		logic [CNT_W-1:0] total;
		logic [BND_W-1:0] extent;
	} answer_t;

	typedef struct {
		logic [OP_W-1:0]  op;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [POS_W-1:0] pos;
		bit               fixed;
		answer_t          ans;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [OP_W-1:0] opcode = '0;
	logic [ROW_W-1:0] row_index = '0;
	logic [COL_W-1:0] column_index = '0;
	logic [POS_W-1:0] position = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [ST_W-1:0] status;
	logic [ROW_W-1:0] row_value;
	logic [CNT_W-1:0] entries_in_column;
	logic [CNT_W-1:0] entries_total;
	logic [BND_W-1:0] row_extent;

	sparse_column_store_insert_query i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .row_index(row_index),
		.column_index(column_index), .position(position),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .row_value(row_value),
		.entries_in_column(entries_in_column),
		.entries_total(entries_total), .row_extent(row_extent)
	);

	always #5 clk = ~clk;

	// behavioral store
	int unsigned col_first [MAX_COLUMNS+1];
	logic [ROW_W-1:0] rows_stored [MAX_ENTRIES];
	int unsigned n_stored;
	int unsigned bound;
	int unsigned cols_cfg;

	answer_t pending_answers [$];
	int errors = 0;
	int n_checked = 0;
	int n_inserted = 0;
	longint cycle = 0;
	bit hold_long = 1'b0;
	bit quiet = 1'b0;

	function automatic answer_t store_apply(input logic [OP_W-1:0] op,
			input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
			input logic [POS_W-1:0] pos);
		answer_t a;
		int unsigned lim, first, last, at;
		a = '0;
		lim = (cols_cfg > MAX_COLUMNS) ? MAX_COLUMNS : cols_cfg;
		if (op != OP_NONE) begin
			if (col >= lim) begin
				a.status = ST_COL;
			end else begin
				first = col_first[col];
				last = col_first[col+1];
				if (op == OP_INSERT) begin
					at = first;
					while (at < last && rows_stored[at] < row) at++;
					if (at < last && rows_stored[at] == row) a.status = ST_DUP;
					else if (n_stored >= MAX_ENTRIES) a.status = ST_FULL;
					else begin
						for (int k = n_stored; k > at; k--) rows_stored[k] = rows_stored[k-1];
						rows_stored[at] = row;
						for (int k = col + 1; k <= MAX_COLUMNS; k++) col_first[k]++;
						n_stored++;
						if (row + 1 > bound) bound = row + 1;
					end
				end else if (op == OP_READ) begin
					if (pos < last - first) a.row_value = rows_stored[first + pos];
					else a.status = ST_POS;
				end
				a.in_col = CNT_W'(col_first[col+1] - col_first[col]);
			end
		end
		a.total = CNT_W'(n_stored);
		a.extent = BND_W'(bound);
		return a;
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("mismatch beat %0d %s: got %0d expected %0d", n_checked, what, got, want);
		errors++;
	endtask

	task automatic send(input stim_t s);
		answer_t a;
		a = store_apply(s.op, s.row, s.col, s.pos);
		if (s.fixed && a != s.ans) begin
			$display("mismatch table row: model disagrees with typed answer");
			errors++;
		end
		if (a.status == ST_OK && s.op == OP_INSERT && s.col < cols_cfg) n_inserted++;
		in_valid <= 1'b1;
		opcode <= s.op;
		row_index <= s.row;
		column_index <= s.col;
		position <= s.pos;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_answers.push_back(a);
	endtask

	task automatic sender_gap();
		int n;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 15);
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_cols(input int unsigned v);
		cfg_wen <= 1'b1;
		cfg_data <= CFG_W'(v);
		@(posedge clk);
		cfg_wen <= 1'b0;
		cols_cfg = v;
		@(posedge clk);
	endtask

	function automatic stim_t mk(input logic [OP_W-1:0] op, input int row, input int col,
			input int pos);
		stim_t s;
		s.op = op; s.row = ROW_W'(row); s.col = COL_W'(col); s.pos = POS_W'(pos);
		s.fixed = 1'b0; s.ans = '0;
		return s;
	endfunction

	function automatic stim_t mk_fixed(input logic [OP_W-1:0] op, input int row, input int col,
			input int pos, input answer_t a);
		stim_t s;
		s = mk(op, row, col, pos);
		s.fixed = 1'b1;
		s.ans = a;
		return s;
	endfunction

	function automatic answer_t ans(input int st, input int rv, input int ic, input int tot,
			input int ext);
		answer_t a;
		a.status = ST_W'(st); a.row_value = ROW_W'(rv); a.in_col = CNT_W'(ic);
		a.total = CNT_W'(tot); a.extent = BND_W'(ext);
		return a;
	endfunction

	function automatic stim_t rand_item(input int unsigned hot);
		stim_t s;
		int r;
		r = $urandom_range(0, 99);
		s = mk(r < 50 ? OP_INSERT : (r < 70 ? OP_COUNT : (r < 95 ? OP_READ : OP_NONE)),
			$urandom, $urandom_range(0, 9) < 7 ? $urandom_range(0, hot) : $urandom,
			$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 6));
		return s;
	endfunction

	// receiver side
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			answer_t w;
			if (pending_answers.size() == 0) begin
				$display("mismatch: result beat with nothing expected");
				errors++;
			end else begin
				w = pending_answers.pop_front();
				if (status !== w.status) report("status", int'(status), int'(w.status));
				if (row_value !== w.row_value)
					report("row_value", int'(row_value), int'(w.row_value));
				if (entries_in_column !== w.in_col)
					report("entries_in_column", int'(entries_in_column), int'(w.in_col));
				if (entries_total !== w.total)
					report("entries_total", int'(entries_total), int'(w.total));
				if (row_extent !== w.extent)
					report("row_extent", int'(row_extent), int'(w.extent));
				n_checked++;
			end
		end
	end

	initial begin : rx_idle
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_long) begin
				out_stall <= 1'b1;
				repeat (3000) @(posedge clk);
				out_stall <= 1'b0;
				hold_long = 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 15);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > 3000000) begin
			$display("timeout after %0d cycles", cycle);
			$display("sparse_column_store_insert_query verification failed");
			$finish;
		end
	end

	initial begin : stim
		stim_t table_rows [$];
		foreach (col_first[i]) col_first[i] = 0;
		n_stored = 0;
		bound = 0;
		cols_cfg = MAX_COLUMNS;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		table_rows.push_back(mk_fixed(OP_COUNT, 0, 0, 0, ans(ST_OK, 0, 0, 0, 0)));
		table_rows.push_back(mk_fixed(OP_READ, 0, 255, 0, ans(ST_POS, 0, 0, 0, 0)));
		table_rows.push_back(mk_fixed(OP_INSERT, 1023, 255, 0, ans(ST_OK, 0, 1, 1, 1024)));
		table_rows.push_back(mk_fixed(OP_INSERT, 1023, 255, 0, ans(ST_DUP, 0, 1, 1, 1024)));
		table_rows.push_back(mk_fixed(OP_INSERT, 0, 0, 0, ans(ST_OK, 0, 1, 2, 1024)));
		table_rows.push_back(mk_fixed(OP_READ, 0, 255, 0, ans(ST_OK, 1023, 1, 2, 1024)));
		table_rows.push_back(mk_fixed(OP_READ, 0, 0, 4095, ans(ST_POS, 0, 1, 2, 1024)));
		table_rows.push_back(mk_fixed(OP_NONE, 1023, 255, 4095, ans(ST_OK, 0, 0, 2, 1024)));
		table_rows.push_back(mk(OP_INSERT, 5, 3, 0));
		table_rows.push_back(mk(OP_INSERT, 2, 3, 0));
		table_rows.push_back(mk(OP_INSERT, 9, 3, 0));
		table_rows.push_back(mk(OP_INSERT, 682, 3, 0));
		table_rows.push_back(mk(OP_INSERT, 341, 3, 0));
		table_rows.push_back(mk(OP_READ, 0, 3, 0));
		table_rows.push_back(mk(OP_READ, 0, 3, 2));
		table_rows.push_back(mk(OP_READ, 0, 3, 4));
		table_rows.push_back(mk(OP_COUNT, 0, 3, 0));
		table_rows.push_back(mk(OP_READ, 0, 170, 2730));
		foreach (table_rows[i]) begin
			send(table_rows[i]);
			sender_gap();
		end
		drain();

		// few columns: only column 0 in range, then none with a count of 0
		write_cols(1);
		send(mk_fixed(OP_COUNT, 0, 1, 0, ans(ST_COL, 0, 0, n_stored, bound)));
		send(mk(OP_READ, 0, 0, 0));
		send(mk(OP_INSERT, 7, 0, 0));
		drain();
		write_cols(0);
		send(mk_fixed(OP_INSERT, 3, 0, 0, ans(ST_COL, 0, 0, n_stored, bound)));
		drain();
		write_cols(511);

		// back pressure: receiver holds while the sender keeps offering
		hold_long = 1'b1;
		repeat (20) send(rand_item(7));
		drain();

		// random, mid column counts, then all 256 columns
		write_cols($urandom_range(4, 12));
		repeat (40) begin
			send(rand_item(15));
			sender_gap();
		end
		drain();
		write_cols(256);
		repeat (30) begin
			send(rand_item(255));
			sender_gap();
		end
		drain();
		quiet = 1'b1;
		repeat (25) send(rand_item(10));
		drain();

		$display("covered %0d checked results, %0d accepted inserts, %0d entries stored",
			n_checked, n_inserted, n_stored);
		$display("column counts 1, 0, 511, mid and 256; long receiver hold and idle bursts");
		if (errors == 0) begin
			$display("sparse_column_store_insert_query verification clean");
		end else begin
			$display("sparse_column_store_insert_query verification failed");
		end
		$finish;
	end
endmodule
